// File: hdl/ebsf_pkg.sv
package ebsf_pkg;

  // Input mode codes, also used as the command op between front and back
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_NOT_CONN = 2'd1,
    KIND_SAMPLE   = 2'd2
  } kind_e;

  // One classified command in flight from front to back
  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
    logic       connected;
  } cmd_t;

  localparam int ByteW    = 8;
  localparam int RawW     = 16;
  localparam int NumW     = 32;
  localparam int ScaledW  = 21;
  localparam int Divisor  = 4095;
  // Guard bits of the reciprocal; must be at least RawW for an error under one
  localparam int GuardW   = 16;
  localparam logic [3:0] SkipNibble = 4'hF;

endpackage

// File: hdl/ecg_byte_pair_sample_framer.sv
// Channel | Signals                                         | Dir
// in      | in_valid_i/in_stall_o, mode_i, byte_value_i,    | item in
//         | device_connected_i                              |
// out     | out_valid_o/out_stall_i, kind_o, sample_*_o,    | result out
//         | bytes_lost_o                                    |
// A beat is taken into a two-entry command queue; the back end drains it.
// Bytes are handled in the idle state; a service tick steps through RD1 and RD2
// (and RD3 when a byte is skipped), then MUL and FIX, set by the single read port
// of the byte store and the multiply/correct steps of the divide by 4095.
// Reset (rst_ni low, asynchronous) empties the byte queue and goes idle.
// A stalled result holds in the output register while the next command is read.
module ecg_byte_pair_sample_framer #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         byte_value_i,
  input  logic               device_connected_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [31:0]        sample_number_o,
  output logic [15:0]        sample_raw_o,
  output logic signed [20:0] sample_scaled_o,
  output logic               bytes_lost_o
);

  logic           push, q_full, pop, q_valid;
  ebsf_pkg::cmd_t cmd_in, cmd_out;

  ebsf_front u_front (
    .in_valid_i         (in_valid_i),
    .mode_i             (mode_i),
    .byte_value_i       (byte_value_i),
    .device_connected_i (device_connected_i),
    .q_full_i           (q_full),
    .in_stall_o         (in_stall_o),
    .push_o             (push),
    .cmd_o              (cmd_in)
  );

  ebsf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  ebsf_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .sample_number_o (sample_number_o),
    .sample_raw_o    (sample_raw_o),
    .sample_scaled_o (sample_scaled_o),
    .bytes_lost_o    (bytes_lost_o)
  );

endmodule

// File: hdl/ebsf_front.sv
module ebsf_front (
  input  logic              in_valid_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        byte_value_i,
  input  logic              device_connected_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output ebsf_pkg::cmd_t    cmd_o
);

  ebsf_pkg::op_e op;
  logic          drop;

  // Decode the mode field
  always_comb begin
    unique case (mode_i)
      2'd0:    op = ebsf_pkg::OP_BYTE;
      2'd1:    op = ebsf_pkg::OP_START;
      2'd2:    op = ebsf_pkg::OP_STOP;
      default: op = ebsf_pkg::OP_TICK;
    endcase
  end

  // A byte from a disconnected device changes nothing: swallow it here
  assign drop = (op == ebsf_pkg::OP_BYTE) && !device_connected_i;

  assign in_stall_o       = q_full_i;
  assign push_o           = in_valid_i && !q_full_i && !drop;
  assign cmd_o.op         = op;
  assign cmd_o.byte_value = byte_value_i;
  assign cmd_o.connected  = device_connected_i;

endmodule

// File: hdl/ebsf_cmd_queue.sv
module ebsf_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ebsf_pkg::cmd_t    cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ebsf_pkg::cmd_t    cmd_o
);

  ebsf_pkg::cmd_t entry_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_q];

  // Two-entry ring of commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= cmd_i;
  end

endmodule

// File: hdl/ebsf_back.sv
module ebsf_back #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  ebsf_pkg::cmd_t           cmd_i,
  output logic                     cmd_pop_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [1:0]               kind_o,
  output logic [31:0]              sample_number_o,
  output logic [15:0]              sample_raw_o,
  output logic signed [20:0]       sample_scaled_o,
  output logic                     bytes_lost_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = FRACTION_BITS + 5;                  // quotient width
  localparam int PW = ebsf_pkg::RawW + QW;                // product width
  localparam int RW = ebsf_pkg::RawW + FRACTION_BITS + 1; // remainder work width
  localparam int EW = (QW > ebsf_pkg::ScaledW) ? QW : ebsf_pkg::ScaledW;
  localparam longint unsigned RecipL =
    (64'd1 << (FRACTION_BITS + ebsf_pkg::GuardW)) / 64'(ebsf_pkg::Divisor);
  localparam logic [QW-1:0] Recip = QW'(RecipL);
  localparam logic [EW-1:0] Half  = EW'(64'd1 << (FRACTION_BITS - 1));
  localparam logic [RW-1:0] DivR  = RW'(ebsf_pkg::Divisor);
  localparam logic [CW-1:0] Full  = CW'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_RD3  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIX  = 3'd5;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(QUEUE_DEPTH - 1)) r = '0;
    else                           r = p + AW'(1);
    return r;
  endfunction

  logic [2:0]          state_q;
  logic [AW-1:0]       rp_q, wp_q;
  logic [CW-1:0]       count_q;
  logic                running_q, lost_q;
  logic [31:0]         counter_q;
  logic [7:0]          mem [QUEUE_DEPTH];
  logic [7:0]          rdata_q, lo_q;
  logic [15:0]         raw_q;
  logic [PW-1:0]       prod_q;
  logic                out_valid_q;
  logic                out_valid_d;
  ebsf_pkg::kind_e     kind_q;
  logic [31:0]         num_q;
  logic [15:0]         raw_out_q;
  logic [20:0]         scaled_q;
  logic                lost_out_q;

  logic [AW-1:0]       rp1, rp2, raddr;
  logic                out_free, mem_we, tick_ok, want_run;
  logic                ack_set, sample_set;
  logic [QW-1:0]       quo;
  logic [RW-1:0]       rem;
  logic                corr;
  logic [EW-1:0]       scaled_full;

  assign rp1      = ptr_inc(rp_q);
  assign rp2      = ptr_inc(rp1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign want_run = (cmd_i.op == ebsf_pkg::OP_START);
  assign tick_ok  = running_q && cmd_i.connected && (count_q >= CW'(2));

  // Pop a command from the idle state; acks wait for a free result slot
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i &&
                     ((cmd_i.op == ebsf_pkg::OP_BYTE) ||
                      (cmd_i.op == ebsf_pkg::OP_TICK) || out_free);

  assign mem_we = cmd_pop_o && (cmd_i.op == ebsf_pkg::OP_BYTE) && (count_q != Full);

  // New results: a run-state change answered, or a finished sample
  assign ack_set    = (state_q == ST_IDLE) && cmd_pop_o &&
                      ((cmd_i.op == ebsf_pkg::OP_START) ||
                       (cmd_i.op == ebsf_pkg::OP_STOP)) && (running_q != want_run);
  assign sample_set = (state_q == ST_FIX) && out_free;

  // Result slot holds while stalled and loads on a new result
  assign out_valid_d = ack_set || sample_set || (out_valid_q && out_stall_i);

  // Read address runs one ahead of the state that uses the data
  always_comb begin
    unique case (state_q)
      ST_IDLE: raddr = rp_q;
      ST_RD1:  raddr = rp1;
      default: raddr = rp2;
    endcase
  end

  // Byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q] <= cmd_i.byte_value;
    rdata_q <= mem[raddr];
  end

  // Divide by 4095: reciprocal estimate, then one correction step
  assign quo  = prod_q[ebsf_pkg::GuardW +: QW];
  assign rem  = {1'b0, raw_q, {FRACTION_BITS{1'b0}}}
              - (RW'({quo, 12'd0}) - RW'(quo));
  assign corr = (rem >= DivR);
  assign scaled_full = EW'(quo) + EW'(corr) - Half;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      running_q   <= 1'b0;
      lost_q      <= 1'b0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.op)
              ebsf_pkg::OP_BYTE: begin
                if (count_q == Full) begin
                  lost_q <= 1'b1;
                end else begin
                  wp_q    <= ptr_inc(wp_q);
                  count_q <= count_q + CW'(1);
                end
              end
              ebsf_pkg::OP_TICK: begin
                if (tick_ok) state_q <= ST_RD1;
              end
              default: begin
                if (running_q != want_run) running_q <= want_run;
              end
            endcase
          end
        end
        ST_RD1: state_q <= ST_RD2;
        ST_RD2: begin
          if (rdata_q[7:4] != 4'd0) begin
            // first byte is out of step: skip it if a third byte is there
            if (count_q < CW'(3)) begin
              state_q <= ST_IDLE;
            end else begin
              rp_q    <= rp1;
              count_q <= count_q - CW'(1);
              state_q <= ST_RD3;
            end
          end else begin
            rp_q    <= rp2;
            count_q <= count_q - CW'(2);
            state_q <= ST_MUL;
          end
        end
        ST_RD3: begin
          rp_q    <= rp2;
          count_q <= count_q - CW'(2);
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_FIX;
        ST_FIX: begin
          if (out_free) begin
            counter_q <= counter_q + 32'd1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD1) lo_q <= rdata_q;
    if (state_q == ST_RD2) begin
      if (rdata_q[7:4] != 4'd0) lo_q  <= rdata_q;
      else                      raw_q <= {rdata_q, lo_q};
    end
    if (state_q == ST_RD3) raw_q <= {rdata_q, lo_q};
    if (state_q == ST_MUL) prod_q <= PW'(raw_q) * PW'(Recip);
    if (state_q == ST_IDLE && cmd_pop_o && (cmd_i.op == ebsf_pkg::OP_START ||
        cmd_i.op == ebsf_pkg::OP_STOP)) begin
      kind_q     <= cmd_i.connected ? ebsf_pkg::KIND_ACK : ebsf_pkg::KIND_NOT_CONN;
      num_q      <= '0;
      raw_out_q  <= '0;
      scaled_q   <= '0;
      lost_out_q <= lost_q;
    end
    if (sample_set) begin
      kind_q     <= ebsf_pkg::KIND_SAMPLE;
      num_q      <= counter_q;
      raw_out_q  <= raw_q;
      scaled_q   <= scaled_full[ebsf_pkg::ScaledW-1:0];
      lost_out_q <= lost_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign sample_number_o = num_q;
  assign sample_raw_o    = raw_out_q;
  assign sample_scaled_o = $signed(scaled_q);
  assign bytes_lost_o    = lost_out_q;

endmodule

// File: hdl/ebsf_checker.sv
module ebsf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic [1:0]         kind_i,
  input logic [31:0]        sample_number_i,
  input logic [15:0]        sample_raw_i,
  input logic signed [20:0] sample_scaled_i,
  input logic               bytes_lost_i
);

  logic        beat;
  logic        is_sample;
  logic [31:0] exp_num_q;
  logic        seen_lost_q;

  assign beat      = out_valid_i && !out_stall_i;
  assign is_sample = (kind_i == ebsf_pkg::KIND_SAMPLE);

  // Shadow of the sample numbering and the sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_num_q   <= '0;
      seen_lost_q <= 1'b0;
    end else if (beat) begin
      if (is_sample)    exp_num_q   <= exp_num_q + 32'd1;
      if (bytes_lost_i) seen_lost_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(kind_i) &&
    $stable(sample_number_i) && $stable(sample_raw_i) && $stable(sample_scaled_i))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == ebsf_pkg::KIND_ACK || kind_i == ebsf_pkg::KIND_NOT_CONN ||
                     kind_i == ebsf_pkg::KIND_SAMPLE))
    else $error("bad result kind");

  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_sample |->
      sample_number_i == '0 && sample_raw_i == '0 && sample_scaled_i == '0)
    else $error("command answer carries sample payload");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_sample |-> sample_number_i == exp_num_q)
    else $error("sample number out of sequence");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_lost_q |-> bytes_lost_i)
    else $error("lost flag cleared");

endmodule

bind ecg_byte_pair_sample_framer ebsf_checker u_ebsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_i          (kind_o),
  .sample_number_i (sample_number_o),
  .sample_raw_i    (sample_raw_o),
  .sample_scaled_i (sample_scaled_o),
  .bytes_lost_i    (bytes_lost_o)
);
